// ===== rtl/core/yrx_pkg.sv =====
// ----------------------------------------------------------------------------
// yrx_pkg
// Shared types and codes of the YMODEM CRC receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package yrx_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_LINK  = 2'd1,
        CMD_START = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } item_t;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] RP_NONE = 3'd0;
    localparam logic [2:0] RP_ACK  = 3'd1;
    localparam logic [2:0] RP_NAK  = 3'd2;
    localparam logic [2:0] RP_CAN  = 3'd3;
    localparam logic [2:0] RP_ACKC = 3'd4;
    localparam logic [2:0] RP_C    = 3'd5;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_DUP     = 4'd1;
    localparam logic [3:0] ST_MARKER  = 4'd2;
    localparam logic [3:0] ST_COMPL   = 4'd3;
    localparam logic [3:0] ST_CRC     = 4'd4;
    localparam logic [3:0] ST_LINK    = 4'd5;
    localparam logic [3:0] ST_CANCEL  = 4'd6;
    localparam logic [3:0] ST_BLOCK   = 4'd7;
    localparam logic [3:0] ST_EXTRA   = 4'd8;
    localparam logic [3:0] ST_HEADER  = 4'd9;
    localparam logic [3:0] ST_NAME    = 4'd10;
    localparam logic [3:0] ST_TRAILER = 4'd11;
    localparam logic [3:0] ST_DONE    = 4'd12;
    localparam logic [3:0] ST_EOT     = 4'd13;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [2:0]  reply;
        logic [3:0]  status;
        logic        commit;
        logic [31:0] file_size;
    } result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ymodem_crc_receiver.sv =====
// ----------------------------------------------------------------------------
// ymodem_crc_receiver
// YMODEM single-file receiver with CRC-16, one link event per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | command, rx_byte
//  result   | pop / empty        | kind, data_byte, reply, status, commit,
//           |                    | file_size
//
//  One input transaction per cycle while full is low; each byte is handled
//  in a single engine step (CRC byte update, counters, header parse, size
//  multiply-add by ten). Inputs pass the registered input and result queues.
//  The engine stalls only when the two-deep result queue is full.
//  Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module ymodem_crc_receiver
    import yrx_pkg::*;
#(
    parameter int NAME_MAX  = 14,
    parameter int SIZE_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [2:0]       reply,
    output logic [3:0]       status,
    output logic             commit,
    output logic [31:0]      file_size
);

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    res_full;
    logic    res_push;
    result_t res;
    result_t head;

    yrx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    yrx_engine #(
        .NAME_MAX  (NAME_MAX),
        .SIZE_BITS (SIZE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    yrx_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign kind      = head.kind;
    assign data_byte = head.data_byte;
    assign reply     = head.reply;
    assign status    = head.status;
    assign commit    = head.commit;
    assign file_size = head.file_size;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && res_full))
        else $error("result pushed into a full queue");

    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> item_valid)
        else $error("engine took an item that was not there");

    a_byte_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_VERDICT) |->
            (reply == RP_NONE && status == ST_OK && !commit && file_size == 32'd0))
        else $error("byte result carries verdict fields");

    a_verdict_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_VERDICT) |-> (data_byte == 8'd0))
        else $error("verdict carries a data byte");

endmodule
`default_nettype wire

// ===== rtl/core/yrx_front.sv =====
// ----------------------------------------------------------------------------
// yrx_front
// Accepts input transactions, classifies the command and queues them (two deep).
// ----------------------------------------------------------------------------
`default_nettype none
module yrx_front
    import yrx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] command,
    input  wire logic [7:0] rx_byte,
    output logic            item_valid,
    output item_t           item,
    input  wire logic       item_take
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_en;
    logic       rd_en;
    item_t      decoded;

    always_comb
    begin
        unique case (command)
            2'd0:    decoded.cmd = CMD_BYTE;
            2'd1:    decoded.cmd = CMD_LINK;
            2'd2:    decoded.cmd = CMD_START;
            default: decoded.cmd = CMD_NONE;
        endcase
        decoded.rx_byte = rx_byte;
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    // drop unknown commands at the door: they change nothing
    assign wr_en      = push && !full && (decoded.cmd != CMD_NONE);
    assign rd_en      = item_take && item_valid;
    assign count_next = count_reg + {1'b0, wr_en} - {1'b0, rd_en};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= decoded;
    end

endmodule
`default_nettype wire

// ===== rtl/core/yrx_engine.sv =====
// ----------------------------------------------------------------------------
// yrx_engine
// Deframes packets, runs the CRC, parses the header and judges each packet.
// ----------------------------------------------------------------------------
`default_nettype none
module yrx_engine
    import yrx_pkg::*;
#(
    parameter int NAME_MAX  = 14,
    parameter int SIZE_BITS = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    input  item_t      item,
    output logic       item_take,
    input  wire logic  res_full,
    output logic       res_push,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_MARK, PH_BLK, PH_CMP, PH_DATA, PH_CRCH, PH_CRCL, PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        SG_HEADER, SG_DATA, SG_TRAILER
    } stage_t;

    localparam logic [4:0] NAME_LIMIT = 5'(NAME_MAX);

    phase_t               phase_reg, phase_next;
    stage_t               stage_reg, stage_next;
    logic [10:0]          pos_reg, pos_next;
    logic                 long_reg, long_next;
    logic [7:0]           blk_reg, blk_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crch_reg, crch_next;
    logic [7:0]           exp_reg, exp_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic [10:0]          kept_reg, kept_next;
    logic [10:0]          skip_reg, skip_next;
    logic                 f_nul_reg, f_nul_next;
    logic                 f_bad_reg, f_bad_next;
    logic                 f_end_reg, f_end_next;
    logic                 f_zero_reg, f_zero_next;
    logic [4:0]           nlen_reg, nlen_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;

    logic        fire;
    logic        emit;
    logic [10:0] len;
    logic [10:0] pos_inc;
    logic [10:0] skip_dec;
    logic [4:0]  nlen_inc;
    logic [7:0]  b;

    assign fire      = item_valid && !res_full;
    assign item_take = fire;
    assign res_push  = fire && emit;
    assign len       = long_reg ? LEN_LONG : LEN_SHORT;
    assign pos_inc   = pos_reg + 11'd1;
    assign b         = item.rx_byte;
    assign nlen_inc  = (nlen_reg < 5'd31) ? nlen_reg + 5'd1 : nlen_reg;
    assign skip_dec  = (skip_reg != 11'd0) ? skip_reg - 11'd1 : skip_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        pos_next    = pos_reg;
        long_next   = long_reg;
        blk_next    = blk_reg;
        crc_next    = crc_reg;
        crch_next   = crch_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        kept_next   = kept_reg;
        skip_next   = skip_reg;
        f_nul_next  = f_nul_reg;
        f_bad_next  = f_bad_reg;
        f_end_next  = f_end_reg;
        f_zero_next = f_zero_reg;
        nlen_next   = nlen_reg;
        size_next   = size_reg;
        emit        = 1'b0;
        res         = '0;
        res.kind    = KIND_VERDICT;

        // a failure: 0 = none, else the cause; eot marks a stray EOT
        begin : proc
            logic       do_fail;
            logic       is_eot;
            logic [3:0] cause;
            do_fail = 1'b0;
            is_eot  = 1'b0;
            cause   = ST_OK;

            if (item.cmd == CMD_START)
            begin
                phase_next  = PH_MARK;
                stage_next  = SG_HEADER;
                pos_next    = '0;
                long_next   = 1'b0;
                blk_next    = '0;
                crc_next    = '0;
                crch_next   = '0;
                exp_next    = 8'd1;
                rem_next    = '0;
                kept_next   = '0;
                skip_next   = '0;
                f_nul_next  = 1'b0;
                f_bad_next  = 1'b0;
                f_end_next  = 1'b0;
                f_zero_next = 1'b0;
                nlen_next   = '0;
                size_next   = '0;
                emit        = 1'b1;
                res.reply   = RP_C;
            end
            else if (phase_reg == PH_IDLE)
            begin
                emit = 1'b0;
            end
            else if (item.cmd == CMD_LINK)
            begin
                do_fail = 1'b1;
                cause   = ST_LINK;
            end
            else
            begin
                unique case (phase_reg)
                    PH_MARK:
                    begin
                        if (b == CH_CAN)
                        begin
                            do_fail = 1'b1;
                            cause   = ST_CANCEL;
                        end
                        else if (b == CH_EOT)
                        begin
                            if (stage_reg != SG_DATA)
                            begin
                                do_fail = 1'b1;
                                is_eot  = 1'b1;
                                cause   = ST_HEADER;
                            end
                            else
                            begin
                                stage_next = SG_TRAILER;
                                emit       = 1'b1;
                                res.reply  = RP_ACKC;
                                res.status = ST_EOT;
                            end
                        end
                        else if (b != CH_SOH && b != CH_STX)
                        begin
                            do_fail = 1'b1;
                            cause   = ST_MARKER;
                        end
                        else
                        begin
                            long_next  = (b == CH_STX);
                            phase_next = PH_BLK;
                        end
                    end
                    PH_BLK:
                    begin
                        blk_next   = b;
                        phase_next = PH_CMP;
                    end
                    PH_CMP:
                    begin
                        if ((blk_reg + b) != 8'hFF)
                        begin
                            skip_next  = len + 11'd2;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            pos_next  = '0;
                            crc_next  = '0;
                            kept_next = '0;
                            if (stage_reg != SG_DATA)
                            begin
                                f_nul_next  = 1'b0;
                                f_bad_next  = 1'b0;
                                f_end_next  = 1'b0;
                                f_zero_next = 1'b0;
                                nlen_next   = '0;
                                size_next   = '0;
                            end
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        crc_next = crc_step(crc_reg, b);
                        unique case (stage_reg)
                            SG_HEADER:
                            begin
                                if (!f_nul_reg)
                                begin
                                    if (b == 8'h00)
                                    begin
                                        f_nul_next = 1'b1;
                                        if (pos_reg == 11'd0)
                                            f_zero_next = 1'b1;
                                        if (pos_inc == len)
                                            f_bad_next = 1'b1;
                                    end
                                    else
                                    begin
                                        nlen_next = nlen_inc;
                                        if (nlen_inc > NAME_LIMIT || b == "/" ||
                                            b == "(" || b == ")")
                                            f_bad_next = 1'b1;
                                        emit          = 1'b1;
                                        res.kind      = KIND_HEADER;
                                        res.data_byte = b;
                                    end
                                end
                                else if (!f_end_reg)
                                begin
                                    if (b >= "0" && b <= "9")
                                        size_next = (size_reg << 3) + (size_reg << 1)
                                            + {{(SIZE_BITS-4){1'b0}}, 4'(b - "0")};
                                    else
                                        f_end_next = 1'b1;
                                end
                            end
                            SG_DATA:
                            begin
                                if (blk_reg == exp_reg &&
                                    {{(SIZE_BITS-11){1'b0}}, pos_reg} < rem_reg)
                                begin
                                    kept_next     = kept_reg + 11'd1;
                                    emit          = 1'b1;
                                    res.kind      = KIND_DATA;
                                    res.data_byte = b;
                                end
                            end
                            default:
                            begin
                                if (pos_reg == 11'd0 && b == 8'h00)
                                    f_zero_next = 1'b1;
                            end
                        endcase
                        pos_next = pos_inc;
                        if (pos_inc >= len)
                            phase_next = PH_CRCH;
                    end
                    PH_CRCH:
                    begin
                        crch_next  = b;
                        phase_next = PH_CRCL;
                    end
                    PH_CRCL:
                    begin
                        emit = 1'b1;
                        if ({crch_reg, b} != crc_reg)
                        begin
                            do_fail = 1'b1;
                            cause   = ST_CRC;
                        end
                        else
                        begin
                            unique case (stage_reg)
                                SG_HEADER:
                                begin
                                    if (blk_reg != 8'd0)
                                    begin
                                        phase_next = PH_IDLE;
                                        res.reply  = RP_CAN;
                                        res.status = ST_HEADER;
                                    end
                                    else if (f_bad_reg || f_zero_reg || !f_nul_reg)
                                    begin
                                        phase_next = PH_IDLE;
                                        res.reply  = RP_CAN;
                                        res.status = ST_NAME;
                                    end
                                    else
                                    begin
                                        rem_next      = size_reg;
                                        exp_next      = 8'd1;
                                        stage_next    = SG_DATA;
                                        phase_next    = PH_MARK;
                                        res.reply     = RP_ACKC;
                                        res.commit    = 1'b1;
                                        res.file_size = 32'(size_reg);
                                    end
                                end
                                SG_DATA:
                                begin
                                    phase_next = PH_MARK;
                                    if (blk_reg == exp_reg - 8'd1)
                                    begin
                                        res.reply  = RP_ACK;
                                        res.status = ST_DUP;
                                    end
                                    else if (blk_reg != exp_reg)
                                    begin
                                        phase_next = PH_IDLE;
                                        res.reply  = RP_CAN;
                                        res.status = ST_BLOCK;
                                    end
                                    else if (rem_reg == '0)
                                    begin
                                        phase_next = PH_IDLE;
                                        res.reply  = RP_CAN;
                                        res.status = ST_EXTRA;
                                    end
                                    else
                                    begin
                                        rem_next   = rem_reg
                                            - {{(SIZE_BITS-11){1'b0}}, kept_reg};
                                        exp_next   = exp_reg + 8'd1;
                                        res.reply  = RP_ACK;
                                        res.commit = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    if (blk_reg != 8'd0 || !f_zero_reg || rem_reg != '0)
                                    begin
                                        res.reply  = RP_CAN;
                                        res.status = ST_TRAILER;
                                    end
                                    else
                                    begin
                                        res.reply  = RP_ACK;
                                        res.status = ST_DONE;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 11'd0)
                        begin
                            do_fail = 1'b1;
                            cause   = ST_COMPL;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end

            if (do_fail)
            begin
                emit       = 1'b1;
                res        = '0;
                res.kind   = KIND_VERDICT;
                phase_next = PH_IDLE;
                priority if (stage_reg == SG_TRAILER)
                begin
                    res.reply  = RP_CAN;
                    res.status = ST_TRAILER;
                end
                else if (cause == ST_CANCEL)
                begin
                    res.reply  = RP_NONE;
                    res.status = ST_CANCEL;
                end
                else if (stage_reg == SG_HEADER)
                begin
                    res.reply  = RP_CAN;
                    res.status = is_eot ? ST_HEADER : cause;
                end
                else
                begin
                    // data stage: NAK and wait for the resend
                    res.reply  = RP_NAK;
                    res.status = cause;
                    phase_next = PH_MARK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            stage_reg  <= SG_HEADER;
            pos_reg    <= '0;
            long_reg   <= 1'b0;
            blk_reg    <= '0;
            crc_reg    <= '0;
            crch_reg   <= '0;
            exp_reg    <= 8'd1;
            rem_reg    <= '0;
            kept_reg   <= '0;
            skip_reg   <= '0;
            f_nul_reg  <= 1'b0;
            f_bad_reg  <= 1'b0;
            f_end_reg  <= 1'b0;
            f_zero_reg <= 1'b0;
            nlen_reg   <= '0;
            size_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            stage_reg  <= stage_next;
            pos_reg    <= pos_next;
            long_reg   <= long_next;
            blk_reg    <= blk_next;
            crc_reg    <= crc_next;
            crch_reg   <= crch_next;
            exp_reg    <= exp_next;
            rem_reg    <= rem_next;
            kept_reg   <= kept_next;
            skip_reg   <= skip_next;
            f_nul_reg  <= f_nul_next;
            f_bad_reg  <= f_bad_next;
            f_end_reg  <= f_end_next;
            f_zero_reg <= f_zero_next;
            nlen_reg   <= nlen_next;
            size_reg   <= size_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/yrx_result_q.sv =====
// ----------------------------------------------------------------------------
// yrx_result_q
// Two-deep result queue driving the pop side of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module yrx_result_q
    import yrx_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_push,
    input  result_t   res,
    output logic      res_full,
    output logic      empty,
    input  wire logic pop,
    output result_t   head
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       rd_en;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head     = mem_reg[rd_ptr_reg];
    assign rd_en    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, res_push} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            mem_reg[wr_ptr_reg] <= res;
    end

endmodule
`default_nettype wire
